### rtl/hnsl_pkg.sv
// Shared types and constants for the Hamming nearest-sample lookup block.
// Used by the top level and hnsl_div in rtl/ and by the bench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hnsl_pkg;

    // Default sizes of the sample table.
    localparam int TABLE_DEPTH_DEF   = 1024;
    localparam int PATTERN_WIDTH_DEF = 64;
    localparam int COST_WIDTH_DEF    = 16;

    // Fixed field widths of the streams and registers.
    localparam int IDX_W      = 10;
    localparam int IN_PAT_W   = 64;
    localparam int IN_COST_W  = 16;
    localparam int FACT_W     = 7;
    localparam int MULT_W     = 10;
    localparam int SHIFT_W    = 16;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Command codes carried in the input tuser.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FACT_COUNT      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_MULTIPLIER = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_SHIFT      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NONZERO_OFF_GOAL = 8'd3;

    // Saturation limits of the result.
    localparam logic signed [63:0] INT32_MAX_C = 64'sd2147483647;
    localparam logic signed [63:0] INT32_MIN_C = -64'sd2147483648;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_FINISH
    } hnsl_state_t;

    // Status of the iterative divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

### rtl/hamming_nearest_sample_lookup.sv
// Top level of the Hamming nearest-sample lookup: control sequencer, tie accumulator,
// scaling datapath and output register. Uses hnsl_pkg, hnsl_ram, hnsl_score, hnsl_div.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The s_* stream carries commands. tuser selects a load or a query. A load writes one
// table slot (pattern, cost, valid) in the cycle it is accepted and yields no output beat.
// A query with the goal flag set yields a beat of value 0 once the output register is
// free. Any other query walks every slot of the table through the single read port of
// the sample RAM, one slot per cycle, keeps the best agreement score with the sum and
// count of tied costs, scales the sum by a shift-add multiply, adds cost_shift times the
// tie count, and divides by the tie count in an iterative divider that produces one
// quotient bit per cycle. With the default sizes the numerator width NW is 39 bits; the
// table scan takes most of a query's time. One command is in work at a time.
// The m_* stream returns one beat per query. The result sits in an output register, so
// the next command is accepted while that beat waits; a finished query whose beat
// cannot be handed over because the receiver stalls holds the block until it can.
// The cfg_* channel writes the four registers at any time and is always ready.
// After reset a clearing pass walks every slot and marks it invalid; s_tready
// stays low until it is over.

module hamming_nearest_sample_lookup #(
    parameter int TABLE_DEPTH   = hnsl_pkg::TABLE_DEPTH_DEF,
    parameter int PATTERN_WIDTH = hnsl_pkg::PATTERN_WIDTH_DEF,
    parameter int COST_WIDTH    = hnsl_pkg::COST_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Command stream. tdata from bit 0 up: entry_index[9:0], pattern_bits[73:10],
    // entry_cost[89:74], query_is_goal[90], zero padding[95:91].
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,
    // tuser from bit 0 up: command (0 load, 1 query).
    input  wire logic [0:0]  s_tuser,
    // Result stream. tdata from bit 0 up: heuristic_value[31:0].
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    // tuser from bit 0 up: table_empty.
    output logic [0:0]       m_tuser,
    // Register write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int SW   = COST_WIDTH + CW;
    localparam int NW   = SW + hnsl_pkg::MULT_W + 2;
    localparam int MW   = $clog2(PATTERN_WIDTH + 1);
    localparam int RW   = PATTERN_WIDTH + COST_WIDTH + 1;
    localparam int PW2  = hnsl_pkg::SHIFT_W + 1 + CW;
    localparam int MCW  = $clog2(hnsl_pkg::MULT_W);

    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    // Unpacked input fields.
    logic [hnsl_pkg::IDX_W-1:0]     in_idx;
    logic [hnsl_pkg::IN_PAT_W-1:0]  in_pat;
    logic [hnsl_pkg::IN_COST_W-1:0] in_cost;
    logic                           in_goal;

    assign in_idx  = s_tdata[9:0];
    assign in_pat  = s_tdata[73:10];
    assign in_cost = s_tdata[89:74];
    assign in_goal = s_tdata[90];

    // Configuration registers.
    logic [hnsl_pkg::FACT_W-1:0]         fact_count_reg;
    logic [hnsl_pkg::MULT_W-1:0]         cost_multiplier_reg;
    logic signed [hnsl_pkg::SHIFT_W-1:0] cost_shift_reg;
    logic                                nonzero_off_goal_reg;

    // Control state.
    hnsl_pkg::hnsl_state_t state_reg, state_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic           rd_vld_reg, rd_vld_next;
    logic           any_reg, any_next;
    logic [MW-1:0]  best_mis_reg, best_mis_next;
    logic [SW-1:0]  sum_reg, sum_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [MCW-1:0] mul_cnt_reg, mul_cnt_next;
    logic           m_tvalid_reg, m_tvalid_next;

    // Payload registers.
    logic [PATTERN_WIDTH-1:0]    qpat_reg, qpat_next;
    logic [PATTERN_WIDTH-1:0]    mask_reg, mask_next;
    logic signed [NW-1:0]        acc_reg, acc_next;
    logic [NW-1:0]               msum_reg, msum_next;
    logic [hnsl_pkg::MULT_W-1:0] mul_reg, mul_next;
    logic                        neg_reg, neg_next;
    logic [hnsl_pkg::OUT_W-1:0]  res_value_reg, res_value_next;
    logic                        res_empty_reg, res_empty_next;
    logic [hnsl_pkg::OUT_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                        m_tuser_reg, m_tuser_next;

    // RAM port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;

    // Scoring pipeline outputs.
    logic                  sc_valid;
    logic [MW-1:0]         sc_mis;
    logic [COST_WIDTH-1:0] sc_cost;
    logic                  sc_busy;

    // Divider signals.
    logic                div_start;
    logic [NW-1:0]       div_dividend;
    logic [NW-1:0]       div_quotient;
    hnsl_pkg::div_stat_t div_stat;

    // Scaling helpers.
    logic signed [PW2-1:0] shift_ext;
    logic signed [PW2-1:0] cnt_ext;
    logic signed [PW2-1:0] sc_prod;
    logic signed [NW-1:0]  q_signed;
    logic signed [63:0]    q_wide;
    logic [PATTERN_WIDTH-1:0] mask_calc;

    logic in_beat;
    logic out_free;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready  = (state_reg == hnsl_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration writes are taken in any state; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fact_count_reg       <= 7'd64;
            cost_multiplier_reg  <= 10'd1;
            cost_shift_reg       <= '0;
            nonzero_off_goal_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hnsl_pkg::CFG_FACT_COUNT:
                begin
                    fact_count_reg <= cfg_data[hnsl_pkg::FACT_W-1:0];
                end
                hnsl_pkg::CFG_COST_MULTIPLIER:
                begin
                    cost_multiplier_reg <= cfg_data[hnsl_pkg::MULT_W-1:0];
                end
                hnsl_pkg::CFG_COST_SHIFT:
                begin
                    cost_shift_reg <= $signed(cfg_data);
                end
                hnsl_pkg::CFG_NONZERO_OFF_GOAL:
                begin
                    nonzero_off_goal_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // A fact count above the pattern width simply enables every bit.
    always_comb
    begin
        for (int b = 0; b < PATTERN_WIDTH; b++)
        begin
            mask_calc[b] = (fact_count_reg > hnsl_pkg::FACT_W'(b));
        end
    end

    // Offset term cost_shift * count, formed once when the scan is over.
    assign shift_ext = PW2'(cost_shift_reg);
    assign cnt_ext   = PW2'($signed({1'b0, cnt_reg}));
    assign sc_prod   = shift_ext * cnt_ext;

    // The divider works on the magnitude; the sign is put back on the quotient, which
    // gives truncation toward zero.
    assign div_dividend = acc_reg[NW-1] ? NW'(-acc_reg) : NW'(acc_reg);
    assign q_signed     = neg_reg ? $signed(-div_quotient) : $signed(div_quotient);
    assign q_wide       = 64'(q_signed);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rd_vld_next    = 1'b0;
        any_next       = any_reg;
        best_mis_next  = best_mis_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        mul_cnt_next   = mul_cnt_reg;
        qpat_next      = qpat_reg;
        mask_next      = mask_reg;
        acc_next       = acc_reg;
        msum_next      = msum_reg;
        mul_next       = mul_reg;
        neg_next       = neg_reg;
        res_value_next = res_value_reg;
        res_empty_next = res_empty_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = '0;
        div_start      = 1'b0;

        // Tie accumulation for every scored slot that leaves the pipeline.
        if (sc_valid)
        begin
            if (!any_reg || (sc_mis < best_mis_reg))
            begin
                any_next      = 1'b1;
                best_mis_next = sc_mis;
                sum_next      = SW'(sc_cost);
                cnt_next      = CW'(1);
            end
            else if (sc_mis == best_mis_reg)
            begin
                sum_next = sum_reg + SW'(sc_cost);
                cnt_next = cnt_reg + 1'b1;
            end
        end

        case (state_reg)
            hnsl_pkg::ST_CLEAR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_SLOT)
                begin
                    idx_next   = '0;
                    state_next = hnsl_pkg::ST_IDLE;
                end
            end
            hnsl_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (s_tuser[0] == hnsl_pkg::CMD_LOAD)
                    begin
                        ram_we    = (32'(in_idx) < TABLE_DEPTH);
                        ram_waddr = AW'(in_idx);
                        ram_wdata = {1'b1, COST_WIDTH'(in_cost), in_pat[PATTERN_WIDTH-1:0]};
                    end
                    else if (in_goal)
                    begin
                        res_value_next = '0;
                        res_empty_next = 1'b0;
                        state_next     = hnsl_pkg::ST_FINISH;
                    end
                    else
                    begin
                        qpat_next  = in_pat[PATTERN_WIDTH-1:0];
                        mask_next  = mask_calc;
                        any_next   = 1'b0;
                        best_mis_next = '0;
                        sum_next   = '0;
                        cnt_next   = '0;
                        idx_next   = '0;
                        state_next = hnsl_pkg::ST_SCAN;
                    end
                end
            end
            hnsl_pkg::ST_SCAN:
            begin
                rd_vld_next = 1'b1;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == LAST_SLOT)
                begin
                    idx_next   = '0;
                    state_next = hnsl_pkg::ST_DRAIN;
                end
            end
            hnsl_pkg::ST_DRAIN:
            begin
                // Wait until the last read has been scored and accumulated.
                if (!rd_vld_reg && !sc_busy)
                begin
                    if (cnt_reg == '0)
                    begin
                        res_value_next = '0;
                        res_empty_next = 1'b1;
                        state_next     = hnsl_pkg::ST_FINISH;
                    end
                    else
                    begin
                        acc_next     = NW'(sc_prod);
                        msum_next    = NW'(sum_reg);
                        mul_next     = cost_multiplier_reg;
                        mul_cnt_next = '0;
                        state_next   = hnsl_pkg::ST_MUL;
                    end
                end
            end
            hnsl_pkg::ST_MUL:
            begin
                // One multiplier bit per cycle, least significant first.
                if (mul_reg[0])
                begin
                    acc_next = acc_reg + $signed(msum_reg);
                end
                msum_next    = msum_reg << 1;
                mul_next     = mul_reg >> 1;
                mul_cnt_next = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == MCW'(hnsl_pkg::MULT_W - 1))
                begin
                    state_next = hnsl_pkg::ST_DSTART;
                end
            end
            hnsl_pkg::ST_DSTART:
            begin
                div_start  = 1'b1;
                neg_next   = acc_reg[NW-1];
                state_next = hnsl_pkg::ST_DIV;
            end
            hnsl_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (q_wide > hnsl_pkg::INT32_MAX_C)
                    begin
                        res_value_next = 32'h7FFF_FFFF;
                    end
                    else if (q_wide < hnsl_pkg::INT32_MIN_C)
                    begin
                        res_value_next = 32'h8000_0000;
                    end
                    else if ((q_wide == 64'sd0) && nonzero_off_goal_reg)
                    begin
                        res_value_next = 32'd1;
                    end
                    else
                    begin
                        res_value_next = q_wide[31:0];
                    end
                    res_empty_next = 1'b0;
                    state_next     = hnsl_pkg::ST_FINISH;
                end
            end
            hnsl_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_value_reg;
                    m_tuser_next  = res_empty_reg;
                    state_next    = hnsl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hnsl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hnsl_pkg::ST_CLEAR;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            any_reg      <= 1'b0;
            best_mis_reg <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            mul_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            rd_vld_reg   <= rd_vld_next;
            any_reg      <= any_next;
            best_mis_reg <= best_mis_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            mul_cnt_reg  <= mul_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qpat_reg      <= qpat_next;
        mask_reg      <= mask_next;
        acc_reg       <= acc_next;
        msum_reg      <= msum_next;
        mul_reg       <= mul_next;
        neg_reg       <= neg_next;
        res_value_reg <= res_value_next;
        res_empty_reg <= res_empty_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    // Each RAM word holds {valid, cost, pattern}.
    hnsl_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    hnsl_score #(
        .PATTERN_WIDTH (PATTERN_WIDTH),
        .COST_WIDTH    (COST_WIDTH)
    ) u_score (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (rd_vld_reg && ram_rdata[RW-1]),
        .sample_pat   (ram_rdata[PATTERN_WIDTH-1:0]),
        .sample_cost  (ram_rdata[RW-2:PATTERN_WIDTH]),
        .query_pat    (qpat_reg),
        .fact_mask    (mask_reg),
        .out_valid    (sc_valid),
        .out_mismatch (sc_mis),
        .out_cost     (sc_cost),
        .pipe_busy    (sc_busy)
    );

    hnsl_div #(
        .NW (NW),
        .DW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // An empty-table beat always carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("empty-table result with nonzero value");

    // The tie count can never exceed the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(TABLE_DEPTH))
        else $error("tie count exceeds table depth");

    // The divider is never restarted while a division is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // No command is taken while the scan pipeline still holds slot reads.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg || sc_busy) |-> !s_tready)
        else $error("command accepted during a table scan");

endmodule

`default_nettype wire

### rtl/hnsl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module hnsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/hnsl_score.sv
// Scoring pipeline: masked difference, per-byte bit counts, then the total mismatch count.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module hnsl_score #(
    parameter int PATTERN_WIDTH = 64,
    parameter int COST_WIDTH = 16,
    localparam int MW = $clog2(PATTERN_WIDTH + 1)
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [PATTERN_WIDTH-1:0] sample_pat,
    input  wire logic [COST_WIDTH-1:0]    sample_cost,
    input  wire logic [PATTERN_WIDTH-1:0] query_pat,
    input  wire logic [PATTERN_WIDTH-1:0] fact_mask,
    output logic                          out_valid,
    output logic [MW-1:0]                 out_mismatch,
    output logic [COST_WIDTH-1:0]         out_cost,
    output logic                          pipe_busy
);

    localparam int NG = (PATTERN_WIDTH + 7) / 8;

    logic                     a_vld_reg;
    logic [PATTERN_WIDTH-1:0] a_diff_reg;
    logic [COST_WIDTH-1:0]    a_cost_reg;
    logic                     b_vld_reg;
    logic [3:0]               b_grp_reg [NG];
    logic [COST_WIDTH-1:0]    b_cost_reg;
    logic                     c_vld_reg;
    logic [MW-1:0]            c_mis_reg;
    logic [COST_WIDTH-1:0]    c_cost_reg;

    logic [NG*8-1:0] diff_pad;
    logic [3:0]      grp_next [NG];
    logic [MW-1:0]   mis_next;

    assign diff_pad = (NG * 8)'(a_diff_reg);

    // Each byte is counted on its own; the bytes are summed one stage later.
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < 8; k++)
            begin
                grp_next[g] = grp_next[g] + 4'(diff_pad[g*8+k]);
            end
        end
    end

    always_comb
    begin
        mis_next = '0;
        for (int g = 0; g < NG; g++)
        begin
            mis_next = mis_next + MW'(b_grp_reg[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_diff_reg <= (sample_pat ^ query_pat) & fact_mask;
        a_cost_reg <= sample_cost;
        b_grp_reg  <= grp_next;
        b_cost_reg <= a_cost_reg;
        c_mis_reg  <= mis_next;
        c_cost_reg <= b_cost_reg;
    end

    assign out_valid    = c_vld_reg;
    assign out_mismatch = c_mis_reg;
    assign out_cost     = c_cost_reg;
    assign pipe_busy    = a_vld_reg | b_vld_reg | c_vld_reg;

endmodule

`default_nettype wire

### rtl/hnsl_div.sv
// Unsigned restoring divider that produces one quotient bit per cycle.
// Depends on hnsl_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module hnsl_div #(
    parameter int NW = 8,
    parameter int DW = 4,
    localparam int SCW = $clog2(NW + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [NW-1:0]         dividend,
    input  wire logic [DW-1:0]         divisor,
    output logic      [NW-1:0]         quotient,
    output hnsl_pkg::div_stat_t        stat
);

    logic [DW:0]     rem_reg;
    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   dvs_reg;
    logic [SCW-1:0]  step_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [DW:0] rem_sh;
    logic [DW:0] rem_diff;
    logic        fits;

    assign rem_sh   = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign fits     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == SCW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_diff : rem_sh;
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

### bench/tb_hamming_nearest_sample_lookup.sv
// Self-checking bench for hamming_nearest_sample_lookup: a cost predictor class scores
// every accepted query against its own copy of the sample table and checks each result beat.
// Depends on rtl/hnsl_pkg.sv and the RTL of the block.
`timescale 1ns / 1ps

module tb_hamming_nearest_sample_lookup;

    localparam int TABLE_DEPTH   = hnsl_pkg::TABLE_DEPTH_DEF;
    localparam int PATTERN_WIDTH = hnsl_pkg::PATTERN_WIDTH_DEF;

    // A query scans the whole table, then multiplies and divides; this covers one
    // query with a good margin and is used as the quiet time before register writes.
    localparam int SETTLE_CYCLES    = 1200;
    // Length of the stretch in which the receiver refuses every result beat.
    localparam int LONG_HOLD_CYCLES = 4000;
    localparam int PHASE_ITEMS      = 90;
    localparam int REPORT_LIMIT     = 10;

    // One expected result beat.
    typedef struct packed {
        bit        empty;
        bit [31:0] value;
    } cost_beat_t;

    // Keeps a private copy of the sample table and the registers, works out the
    // result of every accepted query and compares the result beats in order.
    class nearest_cost_board;
        bit [63:0]         table_pattern [TABLE_DEPTH];
        bit [15:0]         table_cost [TABLE_DEPTH];
        bit                table_written [TABLE_DEPTH];
        bit [6:0]          compare_bits;
        bit [9:0]          cost_scale;
        bit signed [15:0]  cost_offset;
        bit                lift_zero;
        cost_beat_t        expected_costs [$];
        int                mismatches;
        int                beats_seen;

        function new();
            foreach (table_written[i])
                table_written[i] = 1'b0;
            compare_bits = 7'd64;
            cost_scale   = 10'd1;
            cost_offset  = '0;
            lift_zero    = 1'b0;
            mismatches   = 0;
            beats_seen   = 0;
        endfunction

        function void write_register(bit [7:0] index, bit [15:0] data);
            case (index)
                hnsl_pkg::CFG_FACT_COUNT:       compare_bits = data[6:0];
                hnsl_pkg::CFG_COST_MULTIPLIER:  cost_scale   = data[9:0];
                hnsl_pkg::CFG_COST_SHIFT:       cost_offset  = data;
                hnsl_pkg::CFG_NONZERO_OFF_GOAL: lift_zero    = data[0];
                default: ;
            endcase
        endfunction

        function void note_command(bit cmd, bit [9:0] idx, bit [63:0] pat,
                                   bit [15:0] cost, bit goal);
            cost_beat_t        beat;
            int unsigned       width_used;
            bit [63:0]         compare_mask;
            bit                found;
            int unsigned       score;
            int unsigned       best;
            longint unsigned   cost_sum;
            int unsigned       ties;
            longint            numerator;
            longint            quotient;
            if (cmd == hnsl_pkg::CMD_LOAD)
            begin
                if (idx < TABLE_DEPTH)
                begin
                    table_pattern[idx] = pat;
                    table_cost[idx]    = cost;
                    table_written[idx] = 1'b1;
                end
                return;
            end
            beat = '0;
            if (goal)
            begin
                expected_costs = {expected_costs, beat};
                return;
            end
            width_used   = (compare_bits > PATTERN_WIDTH) ? PATTERN_WIDTH : compare_bits;
            compare_mask = (width_used >= 64) ? '1 : ((64'd1 << width_used) - 64'd1);
            found    = 1'b0;
            best     = 0;
            cost_sum = 0;
            ties     = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (!table_written[i])
                    continue;
                score = width_used - $countones((table_pattern[i] ^ pat) & compare_mask);
                if (!found || score > best)
                begin
                    found    = 1'b1;
                    best     = score;
                    cost_sum = table_cost[i];
                    ties     = 1;
                end
                else if (score == best)
                begin
                    cost_sum += table_cost[i];
                    ties++;
                end
            end
            if (ties == 0)
            begin
                beat.empty = 1'b1;
                expected_costs = {expected_costs, beat};
                return;
            end
            numerator = longint'(cost_sum) * longint'(cost_scale)
                      + longint'(cost_offset) * longint'(ties);
            quotient  = numerator / longint'(ties);
            if (quotient > hnsl_pkg::INT32_MAX_C)
                quotient = hnsl_pkg::INT32_MAX_C;
            if (quotient < hnsl_pkg::INT32_MIN_C)
                quotient = hnsl_pkg::INT32_MIN_C;
            if (quotient == 0 && lift_zero)
                quotient = 1;
            beat.value = quotient[31:0];
            expected_costs = {expected_costs, beat};
        endfunction

        function void check_beat(bit [31:0] value, bit empty);
            cost_beat_t want;
            beats_seen++;
            if (expected_costs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result beat %0d arrived with nothing expected: value %0d empty %0b",
                             beats_seen, $signed(value), empty);
                return;
            end
            want = expected_costs.pop_front();
            if (want.value !== value || want.empty !== empty)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result beat %0d: value expected %0d got %0d, empty %0b got %0b",
                             beats_seen, $signed(want.value), $signed(value), want.empty, empty);
            end
        endfunction

        function int pending();
            return expected_costs.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    nearest_cost_board board = new();

    // Idle chances in percent per cycle for each side, and the current random phase.
    // The result side reads phase_no to start its long hold-off in phase four.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int          phase_no;

    // Patterns that went into the table, so that queries can land close to a sample.
    bit [63:0]   known_patterns [$];

    hamming_nearest_sample_lookup DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The run stops here if the block hangs; the slowest correct run is well below this.
    initial
    begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    // Every accepted result beat is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_beat(m_tdata, m_tuser[0]);
    end

    // The result side. It stalls at random at the current rate, and once, at the
    // start of phase four, refuses all beats for a long stretch so that the output
    // register and the finished query behind it fill up and the command side stalls.
    initial
    begin : result_pacing
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (phase_no == 4 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one command beat, with random idle cycles ahead of it, and hands it to
    // the predictor once the block has taken it. The valid stays high after the beat,
    // so that back-to-back beats need no lowering in between.
    task automatic send_command(input bit cmd, input bit [9:0] idx, input bit [63:0] pat,
                                input bit [15:0] cost, input bit goal);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, goal, cost, pat, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_command(cmd, idx, pat, cost, goal);
    endtask

    task automatic write_register(input bit [7:0] index, input bit [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_register(index, data);
    endtask

    // Writes all four registers in a row and then lowers the write valid.
    task automatic apply_settings(input bit [6:0] facts, input bit [9:0] scale,
                                  input bit [15:0] offset, input bit lift);
        write_register(hnsl_pkg::CFG_FACT_COUNT, {9'b0, facts});
        write_register(hnsl_pkg::CFG_COST_MULTIPLIER, {6'b0, scale});
        write_register(hnsl_pkg::CFG_COST_SHIFT, offset);
        write_register(hnsl_pkg::CFG_NONZERO_OFF_GOAL, {15'b0, lift});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering commands, waits for every expected beat and then lets a full
    // query time pass, since a trailing load leaves nothing behind to wait for.
    task automatic drain_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly table loads followed by queries that fall close to a stored sample, so
    // that exact and near matches with ties occur often; the rest is random noise.
    task automatic run_random_items(input int count);
        int unsigned pick;
        bit [9:0]    idx;
        bit [63:0]   pat;
        bit [15:0]   cost;
        bit          goal;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(9);
            if (pick < 2)
                cost = 16'($urandom_range(3));
            else if (pick == 2)
                cost = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            else
                cost = 16'($urandom_range(65535));
            idx  = 10'($urandom_range(1023));
            goal = 1'($urandom_range(1));
            pat  = {$urandom, $urandom};
            if ($urandom_range(99) < 55)
            begin
                // Loads: some go to a few low slots to overwrite, some duplicate a sample.
                if ($urandom_range(3) == 0)
                    idx = 10'($urandom_range(15));
                if (known_patterns.size() != 0 && $urandom_range(99) < 15)
                    pat = known_patterns[$urandom_range(known_patterns.size() - 1)];
                known_patterns = {known_patterns, pat};
                send_command(hnsl_pkg::CMD_LOAD, idx, pat, cost, goal);
            end
            else
            begin
                goal = ($urandom_range(99) < 12);
                if (known_patterns.size() != 0 && $urandom_range(99) < 60)
                begin
                    pat = known_patterns[$urandom_range(known_patterns.size() - 1)];
                    repeat ($urandom_range(3))
                        pat[6'($urandom_range($urandom_range(1) ? 7 : 63))] ^= 1'b1;
                end
                send_command(hnsl_pkg::CMD_QUERY, idx, pat, cost, goal);
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 7;
        recv_idle_pct = 75;
        phase_no      = -1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Zero results are lifted to one here, which must not touch
        // the empty-table answer.
        apply_settings(7'd64, 10'd1, 16'h0000, 1'b1);
        send_command(hnsl_pkg::CMD_QUERY, 10'd0, 64'h0, 16'h0, 1'b0);
        send_command(hnsl_pkg::CMD_QUERY, 10'h3FF, '1, 16'hFFFF, 1'b1);
        send_command(hnsl_pkg::CMD_LOAD, 10'd0, 64'h0, 16'h0000, 1'b0);
        // A perfect match on a zero cost gives zero, reported as one.
        send_command(hnsl_pkg::CMD_QUERY, 10'd0, 64'h0, 16'h0, 1'b0);
        send_command(hnsl_pkg::CMD_LOAD, 10'h3FF, '1, 16'hFFFF, 1'b1);
        send_command(hnsl_pkg::CMD_QUERY, 10'd0, '1, 16'h0, 1'b0);
        // The same pattern in a second slot; both costs enter the average.
        send_command(hnsl_pkg::CMD_LOAD, 10'd512, '1, 16'h0001, 1'b0);
        send_command(hnsl_pkg::CMD_QUERY, 10'd7, '1, 16'h1234, 1'b0);
        send_command(hnsl_pkg::CMD_LOAD, 10'd1, 64'hAAAA_AAAA_AAAA_AAAA, 16'd7, 1'b0);
        // Three slots tie at half agreement and the average is truncated.
        send_command(hnsl_pkg::CMD_QUERY, 10'd0, 64'h5555_5555_5555_5555, 16'h0, 1'b0);
        send_command(hnsl_pkg::CMD_QUERY, 10'd0, 64'h5555_5555_5555_5555, 16'h0, 1'b1);
        send_command(hnsl_pkg::CMD_LOAD, 10'd2, 64'h8000_0000_0000_0001, 16'd100, 1'b0);
        send_command(hnsl_pkg::CMD_QUERY, 10'd0, 64'h8000_0000_0000_0001, 16'h0, 1'b0);
        // Overwrite a slot and query the pattern it used to hold.
        send_command(hnsl_pkg::CMD_LOAD, 10'd2, 64'h0123_4567_89AB_CDEF, 16'd9, 1'b1);
        send_command(hnsl_pkg::CMD_QUERY, 10'd0, 64'h8000_0000_0000_0001, 16'h0, 1'b0);
        send_command(hnsl_pkg::CMD_QUERY, 10'd0, 64'h0123_4567_89AB_CDEF, 16'h0, 1'b0);
        drain_block();

        // Random phases: each starts from an idle block with new register values.
        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 75;
            end
            else if (p < 4)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: apply_settings(7'd64, 10'd1, 16'h0000, 1'b0);
                1: apply_settings(7'd1, 10'd1023, 16'h7FFF, 1'b1);
                2: apply_settings(7'd0, 10'd0, 16'h8000, 1'b0);
                3: apply_settings(7'd127, 10'd1023, 16'h8000, 1'b1);
                4: apply_settings(7'($urandom_range(1, 64)), 10'($urandom_range(1023)),
                                  16'($urandom_range(65535)), 1'($urandom_range(1)));
                default: apply_settings(7'd8, 10'd1, 16'hFFFE, 1'b1);
            endcase
            phase_no = p;
            run_random_items(PHASE_ITEMS);
            drain_block();
        end

        if (board.mismatches == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
